// ----- src/hfa_pkg.sv -----
`timescale 1ns / 1ps
// Package for the half-float adder: default field widths, guard bit count,
// and the control record that travels with every item down the pipeline.
// No dependencies.
package hfa_pkg;

    // Default exponent and fraction widths (binary16 layout).
    localparam int DEF_EXP_WIDTH  = 5;
    localparam int DEF_FRAC_WIDTH = 10;

    // Width of the operand and sum ports.
    localparam int PORT_WIDTH = 16;

    // Guard, round and sticky bits below the significand.
    localparam int GRS_BITS = 3;

    // Control record that moves from stage to stage with each item.
    typedef struct packed {
        logic valid;    // the stage holds an item
        logic sign;     // sign of the result
        logic eff_sub;  // operand signs differ
        logic bypass;   // result word is already known
    } stage_ctrl_t;

endpackage

// ----- src/hfa_unpack.sv -----
`timescale 1ns / 1ps
// First stage of the half-float adder: splits the operands, resolves the
// special cases and orders the operands by magnitude. Depends on hfa_pkg.
module hfa_unpack import hfa_pkg::*; #(
    parameter int EXP_WIDTH  = DEF_EXP_WIDTH,
    parameter int FRAC_WIDTH = DEF_FRAC_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic [PORT_WIDTH-1:0]             operand_a,
    input  logic [PORT_WIDTH-1:0]             operand_b,
    output stage_ctrl_t                       ctrl_out,
    output logic [EXP_WIDTH+FRAC_WIDTH:0]     bypass_word,
    output logic [EXP_WIDTH-1:0]              exp_big,
    output logic [EXP_WIDTH-1:0]              exp_diff,
    output logic [FRAC_WIDTH-1:0]             frac_big,
    output logic [FRAC_WIDTH-1:0]             frac_small
);

    localparam int WORD_WIDTH = EXP_WIDTH + FRAC_WIDTH + 1;

    logic [WORD_WIDTH-1:0] a_word;
    logic [WORD_WIDTH-1:0] b_word;
    logic                  sa;
    logic                  sb;
    logic [EXP_WIDTH-1:0]  ea;
    logic [EXP_WIDTH-1:0]  eb;
    logic [FRAC_WIDTH-1:0] fa;
    logic [FRAC_WIDTH-1:0] fb;
    logic                  a_nan;
    logic                  b_nan;
    logic                  a_inf;
    logic                  b_inf;
    logic                  a_zero;
    logic                  b_zero;
    logic                  swap;
    logic [WORD_WIDTH-1:0] nan_word;

    stage_ctrl_t           ctrl_reg;
    stage_ctrl_t           ctrl_next;
    logic [WORD_WIDTH-1:0] bypass_reg;
    logic [WORD_WIDTH-1:0] bypass_next;
    logic [EXP_WIDTH-1:0]  exp_big_reg;
    logic [EXP_WIDTH-1:0]  exp_big_next;
    logic [EXP_WIDTH-1:0]  exp_diff_reg;
    logic [EXP_WIDTH-1:0]  exp_diff_next;
    logic [FRAC_WIDTH-1:0] frac_big_reg;
    logic [FRAC_WIDTH-1:0] frac_big_next;
    logic [FRAC_WIDTH-1:0] frac_small_reg;
    logic [FRAC_WIDTH-1:0] frac_small_next;

    assign a_word = WORD_WIDTH'(operand_a);
    assign b_word = WORD_WIDTH'(operand_b);
    assign sa     = a_word[WORD_WIDTH-1];
    assign sb     = b_word[WORD_WIDTH-1];
    assign ea     = a_word[WORD_WIDTH-2 -: EXP_WIDTH];
    assign eb     = b_word[WORD_WIDTH-2 -: EXP_WIDTH];
    assign fa     = a_word[FRAC_WIDTH-1:0];
    assign fb     = b_word[FRAC_WIDTH-1:0];
    assign a_nan  = (&ea) && (|fa);
    assign b_nan  = (&eb) && (|fb);
    assign a_inf  = (&ea) && !(|fa);
    assign b_inf  = (&eb) && !(|fb);
    assign a_zero = !(|ea);
    assign b_zero = !(|eb);
    assign swap   = {eb, fb} > {ea, fa};
    assign nan_word = {1'b0, {EXP_WIDTH{1'b1}}, FRAC_WIDTH'(1)};

    always_comb
    begin
        ctrl_next.valid   = in_valid;
        ctrl_next.sign    = swap ? sb : sa;
        ctrl_next.eff_sub = sa ^ sb;
        ctrl_next.bypass  = 1'b1;
        bypass_next       = '0;
        priority if (a_nan || b_nan)
        begin
            bypass_next = nan_word;
        end
        else if (a_inf && b_inf)
        begin
            bypass_next = (sa != sb) ? nan_word
                                     : {sa, {EXP_WIDTH{1'b1}}, {FRAC_WIDTH{1'b0}}};
        end
        else if (a_inf)
        begin
            bypass_next = {sa, {EXP_WIDTH{1'b1}}, {FRAC_WIDTH{1'b0}}};
        end
        else if (b_inf)
        begin
            bypass_next = {sb, {EXP_WIDTH{1'b1}}, {FRAC_WIDTH{1'b0}}};
        end
        else if (a_zero && b_zero)
        begin
            bypass_next = {sa & sb, {(WORD_WIDTH-1){1'b0}}};
        end
        else if (a_zero)
        begin
            bypass_next = b_word;
        end
        else if (b_zero)
        begin
            bypass_next = a_word;
        end
        else
        begin
            ctrl_next.bypass = 1'b0;
        end

        exp_big_next    = swap ? eb : ea;
        exp_diff_next   = swap ? (eb - ea) : (ea - eb);
        frac_big_next   = swap ? fb : fa;
        frac_small_next = swap ? fa : fb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_reg     <= bypass_next;
        exp_big_reg    <= exp_big_next;
        exp_diff_reg   <= exp_diff_next;
        frac_big_reg   <= frac_big_next;
        frac_small_reg <= frac_small_next;
    end

    assign ctrl_out    = ctrl_reg;
    assign bypass_word = bypass_reg;
    assign exp_big     = exp_big_reg;
    assign exp_diff    = exp_diff_reg;
    assign frac_big    = frac_big_reg;
    assign frac_small  = frac_small_reg;

endmodule

// ----- src/hfa_align.sv -----
`timescale 1ns / 1ps
// Second stage of the half-float adder: aligns the smaller significand with
// a sticky bit and adds or subtracts the significands. Depends on hfa_pkg.
module hfa_align import hfa_pkg::*; #(
    parameter int EXP_WIDTH  = DEF_EXP_WIDTH,
    parameter int FRAC_WIDTH = DEF_FRAC_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stage_ctrl_t                            ctrl_in,
    input  logic [EXP_WIDTH+FRAC_WIDTH:0]          bypass_in,
    input  logic [EXP_WIDTH-1:0]                   exp_big,
    input  logic [EXP_WIDTH-1:0]                   exp_diff,
    input  logic [FRAC_WIDTH-1:0]                  frac_big,
    input  logic [FRAC_WIDTH-1:0]                  frac_small,
    output stage_ctrl_t                            ctrl_out,
    output logic [EXP_WIDTH+FRAC_WIDTH:0]          bypass_out,
    output logic [FRAC_WIDTH+GRS_BITS:0]           sig_out,
    output logic signed [EXP_WIDTH+1:0]            exp_out
);

    localparam int WORD_WIDTH = EXP_WIDTH + FRAC_WIDTH + 1;
    localparam int MW         = FRAC_WIDTH + 1 + GRS_BITS;
    localparam int SW         = MW + 1;
    localparam int EW         = EXP_WIDTH + 2;

    logic [MW-1:0]        ma;
    logic [MW-1:0]        mb;
    logic [MW-1:0]        mb_aligned;
    logic [SW-1:0]        sum_full;
    logic signed [EW-1:0] exp_ext;
    logic                 cancel;

    stage_ctrl_t           ctrl_reg;
    stage_ctrl_t           ctrl_next;
    logic [WORD_WIDTH-1:0] bypass_reg;
    logic [WORD_WIDTH-1:0] bypass_next;
    logic [MW-1:0]         sig_reg;
    logic [MW-1:0]         sig_next;
    logic signed [EW-1:0]  exp_reg;
    logic signed [EW-1:0]  exp_next;

    assign ma      = {1'b1, frac_big, {GRS_BITS{1'b0}}};
    assign mb      = {1'b1, frac_small, {GRS_BITS{1'b0}}};
    assign exp_ext = $signed(EW'(exp_big));

    always_comb
    begin
        // A distance past the whole significand leaves only the sticky bit.
        if (int'(exp_diff) >= MW)
        begin
            mb_aligned = MW'(1);
        end
        else
        begin
            mb_aligned = (mb >> exp_diff)
                       | MW'(|(mb & ~({MW{1'b1}} << exp_diff)));
        end

        if (ctrl_in.eff_sub)
        begin
            sum_full = {1'b0, ma} - {1'b0, mb_aligned};
        end
        else
        begin
            sum_full = {1'b0, ma} + {1'b0, mb_aligned};
        end

        cancel = ctrl_in.eff_sub && (sum_full == '0);

        // A carry out of the addition costs one right shift, keeping the sticky bit.
        if (sum_full[SW-1])
        begin
            sig_next = {sum_full[SW-1:2], sum_full[1] | sum_full[0]};
            exp_next = exp_ext + EW'(1);
        end
        else
        begin
            sig_next = sum_full[MW-1:0];
            exp_next = exp_ext;
        end

        ctrl_next        = ctrl_in;
        bypass_next      = bypass_in;
        if (!ctrl_in.bypass && cancel)
        begin
            ctrl_next.bypass = 1'b1;
            bypass_next      = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg <= '0;
        end
        else
        begin
            ctrl_reg <= ctrl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass_reg <= bypass_next;
        sig_reg    <= sig_next;
        exp_reg    <= exp_next;
    end

    assign ctrl_out   = ctrl_reg;
    assign bypass_out = bypass_reg;
    assign sig_out    = sig_reg;
    assign exp_out    = exp_reg;

endmodule

// ----- src/hfa_normalize.sv -----
`timescale 1ns / 1ps
// Third and fourth stages of the half-float adder: counts leading zeros of
// the difference, then shifts it left and lowers the exponent. Uses hfa_pkg.
module hfa_normalize import hfa_pkg::*; #(
    parameter int EXP_WIDTH  = DEF_EXP_WIDTH,
    parameter int FRAC_WIDTH = DEF_FRAC_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stage_ctrl_t                            ctrl_in,
    input  logic [EXP_WIDTH+FRAC_WIDTH:0]          bypass_in,
    input  logic [FRAC_WIDTH+GRS_BITS:0]           sig_in,
    input  logic signed [EXP_WIDTH+1:0]            exp_in,
    output stage_ctrl_t                            ctrl_out,
    output logic [EXP_WIDTH+FRAC_WIDTH:0]          bypass_out,
    output logic [FRAC_WIDTH+GRS_BITS:0]           sig_out,
    output logic signed [EXP_WIDTH+1:0]            exp_out
);

    localparam int WORD_WIDTH = EXP_WIDTH + FRAC_WIDTH + 1;
    localparam int MW         = FRAC_WIDTH + 1 + GRS_BITS;
    localparam int EW         = EXP_WIDTH + 2;
    localparam int LZW        = $clog2(MW);

    function automatic logic [LZW-1:0] lead_zeros(input logic [MW-1:0] value);
        logic [LZW-1:0] count;
        count = '0;
        for (int i = 0; i < MW; i++)
        begin
            if (value[i])
            begin
                count = LZW'(MW - 1 - i);
            end
        end
        return count;
    endfunction

    stage_ctrl_t           ctrl3_reg;
    logic [WORD_WIDTH-1:0] bypass3_reg;
    logic [MW-1:0]         sig3_reg;
    logic signed [EW-1:0]  exp3_reg;
    logic [LZW-1:0]        lz3_reg;
    logic [LZW-1:0]        lz3_next;

    stage_ctrl_t           ctrl4_reg;
    logic [WORD_WIDTH-1:0] bypass4_reg;
    logic [MW-1:0]         sig4_reg;
    logic [MW-1:0]         sig4_next;
    logic signed [EW-1:0]  exp4_reg;
    logic signed [EW-1:0]  exp4_next;

    // A sum always has its leading one on top, so the count is zero for it.
    assign lz3_next  = lead_zeros(sig_in);
    assign sig4_next = sig3_reg << lz3_reg;
    assign exp4_next = exp3_reg - $signed(EW'(lz3_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl3_reg <= '0;
            ctrl4_reg <= '0;
        end
        else
        begin
            ctrl3_reg <= ctrl_in;
            ctrl4_reg <= ctrl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        bypass3_reg <= bypass_in;
        sig3_reg    <= sig_in;
        exp3_reg    <= exp_in;
        lz3_reg     <= lz3_next;
        bypass4_reg <= bypass3_reg;
        sig4_reg    <= sig4_next;
        exp4_reg    <= exp4_next;
    end

    assign ctrl_out   = ctrl4_reg;
    assign bypass_out = bypass4_reg;
    assign sig_out    = sig4_reg;
    assign exp_out    = exp4_reg;

endmodule

// ----- src/hfa_round.sv -----
`timescale 1ns / 1ps
// Last stage of the half-float adder: rounds to nearest even, detects
// overflow and underflow, and packs the sum word. Depends on hfa_pkg.
module hfa_round import hfa_pkg::*; #(
    parameter int EXP_WIDTH  = DEF_EXP_WIDTH,
    parameter int FRAC_WIDTH = DEF_FRAC_WIDTH
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  stage_ctrl_t                            ctrl_in,
    input  logic [EXP_WIDTH+FRAC_WIDTH:0]          bypass_in,
    input  logic [FRAC_WIDTH+GRS_BITS:0]           sig_in,
    input  logic signed [EXP_WIDTH+1:0]            exp_in,
    output logic                                   done,
    output logic [PORT_WIDTH-1:0]                  sum,
    output logic                                   overflowed
);

    localparam int WORD_WIDTH = EXP_WIDTH + FRAC_WIDTH + 1;
    localparam int MW         = FRAC_WIDTH + 1 + GRS_BITS;
    localparam int EW         = EXP_WIDTH + 2;
    localparam int EXP_MAX    = (1 << EXP_WIDTH) - 1;

    logic [FRAC_WIDTH:0]   mant;
    logic [FRAC_WIDTH+1:0] mant_inc;
    logic [FRAC_WIDTH:0]   mant_r;
    logic signed [EW-1:0]  exp_r;
    logic                  round_up;
    logic                  exp_high;
    logic                  exp_low;
    logic [WORD_WIDTH-1:0] word;

    logic                  done_reg;
    logic                  done_next;
    logic [PORT_WIDTH-1:0] sum_reg;
    logic [PORT_WIDTH-1:0] sum_next;
    logic                  ovf_reg;
    logic                  ovf_next;

    assign mant     = sig_in[MW-1:GRS_BITS];
    assign mant_inc = {1'b0, mant} + (FRAC_WIDTH+2)'(1);
    assign round_up = sig_in[2] && (sig_in[1] || sig_in[0] || mant[0]);

    always_comb
    begin
        if (round_up && mant_inc[FRAC_WIDTH+1])
        begin
            mant_r = mant_inc[FRAC_WIDTH+1:1];
            exp_r  = exp_in + EW'(1);
        end
        else if (round_up)
        begin
            mant_r = mant_inc[FRAC_WIDTH:0];
            exp_r  = exp_in;
        end
        else
        begin
            mant_r = mant;
            exp_r  = exp_in;
        end

        exp_high = exp_r >= $signed(EW'(EXP_MAX));
        exp_low  = exp_r[EW-1] || (exp_r == '0);

        priority if (ctrl_in.bypass)
        begin
            word = bypass_in;
        end
        else if (exp_high)
        begin
            word = {ctrl_in.sign, {EXP_WIDTH{1'b1}}, {FRAC_WIDTH{1'b0}}};
        end
        else if (exp_low)
        begin
            word = {ctrl_in.sign, {(WORD_WIDTH-1){1'b0}}};
        end
        else
        begin
            word = {ctrl_in.sign, exp_r[EXP_WIDTH-1:0], mant_r[FRAC_WIDTH-1:0]};
        end

        done_next = ctrl_in.valid;
        sum_next  = word[PORT_WIDTH-1:0];
        ovf_next  = !ctrl_in.bypass && exp_high;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        ovf_reg <= ovf_next;
    end

    assign done       = done_reg;
    assign sum        = sum_reg;
    assign overflowed = ovf_reg;

endmodule

// ----- src/half_float_adder_unit.sv -----
`timescale 1ns / 1ps
// Top level of the half-float adder: a five-stage pipeline built from
// hfa_unpack, hfa_align, hfa_normalize and hfa_round. Depends on hfa_pkg.
//
// This unit adds two floats in sign, exponent, fraction layout (binary16 by
// default, bias 2^(EXP_WIDTH-1)-1) and rounds to nearest, ties to even. An
// item is taken on every rising edge at which start is high; busy is never
// raised, so one operand pair can enter each cycle. The sum of an item shows
// on sum and overflowed for exactly one cycle, marked by done, once it has
// left the last stage; the receiver must take it then, since nothing can hold
// it back. The five stages are: special-case decode and magnitude ordering,
// alignment with sticky bit and add or subtract, leading-zero count, the
// normalizing left shift, and rounding and packing. Inputs with a zero
// exponent count as zero, results below the smallest normal number flush to
// a signed zero, any NaN or infinity of opposite signs gives the quiet NaN
// code with exponent all ones and fraction one, and exact cancellation gives
// plus zero. overflowed is high only when the sum of finite inputs overflows to
// infinity. With wider parameters the sum word is cut to its low 16 bits.
module half_float_adder_unit import hfa_pkg::*; #(
    parameter int EXP_WIDTH  = DEF_EXP_WIDTH,
    parameter int FRAC_WIDTH = DEF_FRAC_WIDTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [PORT_WIDTH-1:0] operand_a,
    input  logic [PORT_WIDTH-1:0] operand_b,
    output logic                  done,
    output logic [PORT_WIDTH-1:0] sum,
    output logic                  overflowed
);

    localparam int WORD_WIDTH = EXP_WIDTH + FRAC_WIDTH + 1;
    localparam int MW         = FRAC_WIDTH + 1 + GRS_BITS;
    localparam int EW         = EXP_WIDTH + 2;

    // Stage one outputs.
    stage_ctrl_t           s1_ctrl;
    logic [WORD_WIDTH-1:0] s1_bypass;
    logic [EXP_WIDTH-1:0]  s1_exp_big;
    logic [EXP_WIDTH-1:0]  s1_exp_diff;
    logic [FRAC_WIDTH-1:0] s1_frac_big;
    logic [FRAC_WIDTH-1:0] s1_frac_small;

    // Stage two outputs.
    stage_ctrl_t           s2_ctrl;
    logic [WORD_WIDTH-1:0] s2_bypass;
    logic [MW-1:0]         s2_sig;
    logic signed [EW-1:0]  s2_exp;

    // Stage four outputs.
    stage_ctrl_t           s4_ctrl;
    logic [WORD_WIDTH-1:0] s4_bypass;
    logic [MW-1:0]         s4_sig;
    logic signed [EW-1:0]  s4_exp;

    logic                  accept;

    // Every stage moves forward each cycle, so the unit never refuses an item.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    hfa_unpack #(
        .EXP_WIDTH  (EXP_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_unpack (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (accept),
        .operand_a   (operand_a),
        .operand_b   (operand_b),
        .ctrl_out    (s1_ctrl),
        .bypass_word (s1_bypass),
        .exp_big     (s1_exp_big),
        .exp_diff    (s1_exp_diff),
        .frac_big    (s1_frac_big),
        .frac_small  (s1_frac_small)
    );

    hfa_align #(
        .EXP_WIDTH  (EXP_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_align (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (s1_ctrl),
        .bypass_in  (s1_bypass),
        .exp_big    (s1_exp_big),
        .exp_diff   (s1_exp_diff),
        .frac_big   (s1_frac_big),
        .frac_small (s1_frac_small),
        .ctrl_out   (s2_ctrl),
        .bypass_out (s2_bypass),
        .sig_out    (s2_sig),
        .exp_out    (s2_exp)
    );

    hfa_normalize #(
        .EXP_WIDTH  (EXP_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_normalize (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (s2_ctrl),
        .bypass_in  (s2_bypass),
        .sig_in     (s2_sig),
        .exp_in     (s2_exp),
        .ctrl_out   (s4_ctrl),
        .bypass_out (s4_bypass),
        .sig_out    (s4_sig),
        .exp_out    (s4_exp)
    );

    hfa_round #(
        .EXP_WIDTH  (EXP_WIDTH),
        .FRAC_WIDTH (FRAC_WIDTH)
    ) u_round (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl_in    (s4_ctrl),
        .bypass_in  (s4_bypass),
        .sig_in     (s4_sig),
        .exp_in     (s4_exp),
        .done       (done),
        .sum        (sum),
        .overflowed (overflowed)
    );

    // Every accepted item comes out, marked by done.
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##5 done)
        else $error("accepted item did not complete after five cycles");

    // No result appears without a matching accepted item.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, 5))
        else $error("result strobe without a matching accepted item");

    // Two positive zeros add to a positive zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(operand_a, 5) == '0 && $past(operand_b, 5) == '0)
        |-> (sum == '0 && !overflowed))
        else $error("zero plus zero did not give plus zero");

endmodule
